[hw/rtl/cubic_bezier_point_evaluator_assert.svh]
// Assertion macros for the curve evaluator. Clock is clk, reset is rst_n.
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define CBPE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cbpe: property failed");
`define CBPE_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cbpe: forbidden condition seen");
`else
`define CBPE_ASSERT(lbl, prop)
`define CBPE_ASSERT_NEVER(lbl, cond)
`endif

`endif

[hw/rtl/cbpe_pkg.sv]
package cbpe_pkg;

    localparam int STEP_BITS   = 8;
    localparam int COORD_WIDTH = 16;
    localparam int NUM_POINTS  = 4;

    localparam int A_W      = STEP_BITS + 1;          // holds 2^STEP_BITS
    localparam int SQ_W     = 2 * STEP_BITS + 1;      // holds a^2
    localparam int MUL_W    = SQ_W + A_W;             // raw cube product
    localparam int WEIGHT_W = 3 * STEP_BITS + 1;      // weights are <= 2^(3*STEP_BITS)
    localparam int PROD_W   = WEIGHT_W + 1 + COORD_WIDTH;
    localparam int SUM_W    = PROD_W + 2;
    localparam int DIV_SHIFT = 3 * STEP_BITS;

    localparam logic [A_W-1:0] STEP_COUNT = A_W'(1) << STEP_BITS;
    localparam logic signed [SUM_W-1:0] DIV_BIAS =
        SUM_W'((64'd1 << DIV_SHIFT) - 64'd1);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X0, REG_X1, REG_X2, REG_X3,
        REG_Y0, REG_Y1, REG_Y2, REG_Y3
    } cfg_reg_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [NUM_POINTS-1:0][COORD_WIDTH-1:0] ctrl_set_t;
    typedef logic [NUM_POINTS-1:0][WEIGHT_W-1:0] weight_set_t;

    // Per-stage load enables for the blend lanes.
    typedef struct packed {
        logic prod;
        logic pair;
        logic sum;
        logic out;
    } lane_adv_t;

endpackage

[hw/rtl/cbpe_blend.sv]
// One coordinate lane: weighted products, adder tree, truncating divide.
module cbpe_blend
    import cbpe_pkg::*;
(
    input  logic        clk,
    input  lane_adv_t   adv,
    input  weight_set_t weight,
    input  ctrl_set_t   ctrl,
    output coord_t      point
);

    logic signed [PROD_W-1:0] prod_reg [NUM_POINTS];
    logic signed [PROD_W-1:0] prod_next [NUM_POINTS];
    logic signed [SUM_W-1:0]  pair_reg [2];
    logic signed [SUM_W-1:0]  pair_next [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  biased;
    coord_t                   point_reg;
    coord_t                   point_next;

    always_comb
    begin
        for (int k = 0; k < NUM_POINTS; k++)
        begin
            prod_next[k] = $signed({1'b0, weight[k]}) * $signed(ctrl[k]);
        end
        pair_next[0] = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
        pair_next[1] = SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);
        sum_next     = pair_reg[0] + pair_reg[1];
        // bias negatives so the shift truncates toward zero
        biased       = sum_reg + (sum_reg[SUM_W-1] ? DIV_BIAS : '0);
        point_next   = biased[DIV_SHIFT +: COORD_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (adv.prod)
        begin
            for (int k = 0; k < NUM_POINTS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (adv.pair)
        begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (adv.sum)
        begin
            sum_reg <= sum_next;
        end
        if (adv.out)
        begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

[hw/rtl/cubic_bezier_point_evaluator.sv]
// Cubic Bezier point evaluator.
// Program the four control points through the write port (cfg_wr_en,
// cfg_index 0..3 for x0..x3, 4..7 for y0..y3, cfg_data) while no request
// is in flight. Each request on the step channel (step_valid, step_stall,
// step_index) yields one point on the point channel (point_valid,
// point_stall, point_x, point_y) at t = step_index / 2^STEP_BITS, computed
// exactly in integers and truncated toward zero.
// An accepted request passes through the six register stages (squares,
// weights, products, pair sums, sum, divide) before point_valid rises.
// Throughput: one request per cycle while point_stall is low; every stage holds a full item.
// When point_stall is high the last stage holds; earlier stages keep
// filling bubbles and step_stall rises only once stage one is occupied and
// cannot move. No request is dropped or repeated.
// Reset clears all valid bits and sets every control point to zero.
`include "cubic_bezier_point_evaluator_assert.svh"

module cubic_bezier_point_evaluator
    import cbpe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic                   step_valid,
    output logic                   step_stall,
    input  logic [STEP_BITS-1:0]   step_index,
    output logic                   point_valid,
    input  logic                   point_stall,
    output coord_t                 point_x,
    output coord_t                 point_y
);

    localparam int NUM_STAGES = 6;

    // control points
    ctrl_set_t ctrl_x_reg;
    ctrl_set_t ctrl_y_reg;

    // valid bit per stage, index 0 is stage one
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    // stage one: step, complement and their squares
    logic [STEP_BITS-1:0] i_reg;
    logic [A_W-1:0]       a_reg;
    logic [SQ_W-1:0]      i2_reg;
    logic [SQ_W-1:0]      a2_reg;
    logic [A_W-1:0]       a_next;

    // stage two: Bernstein weights
    weight_set_t          weight_reg;
    weight_set_t          weight_next;
    logic [MUL_W-1:0]     ia2;
    logic [MUL_W-1:0]     i2a;

    lane_adv_t            lane_adv;

    // Advance a stage when it is empty or the one after it advances.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !point_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[NUM_STAGES-2:0], step_valid};
    end

    assign step_stall  = !adv[0];
    assign point_valid = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_x_reg <= '0;
            ctrl_y_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X0: ctrl_x_reg[0] <= cfg_data;
                REG_X1: ctrl_x_reg[1] <= cfg_data;
                REG_X2: ctrl_x_reg[2] <= cfg_data;
                REG_X3: ctrl_x_reg[3] <= cfg_data;
                REG_Y0: ctrl_y_reg[0] <= cfg_data;
                REG_Y1: ctrl_y_reg[1] <= cfg_data;
                REG_Y2: ctrl_y_reg[2] <= cfg_data;
                REG_Y3: ctrl_y_reg[3] <= cfg_data;
            endcase
        end
    end

    // Stage one and two datapath.
    always_comb
    begin
        a_next = STEP_COUNT - A_W'(step_index);
        ia2    = MUL_W'(a2_reg) * MUL_W'(i_reg);
        i2a    = MUL_W'(i2_reg) * MUL_W'(a_reg);
        weight_next[0] = WEIGHT_W'(MUL_W'(a2_reg) * MUL_W'(a_reg));
        weight_next[1] = WEIGHT_W'(ia2 + (ia2 << 1));
        weight_next[2] = WEIGHT_W'(i2a + (i2a << 1));
        weight_next[3] = WEIGHT_W'(MUL_W'(i2_reg) * MUL_W'(i_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            i_reg  <= step_index;
            a_reg  <= a_next;
            i2_reg <= SQ_W'(step_index) * SQ_W'(step_index);
            a2_reg <= SQ_W'(a_next) * SQ_W'(a_next);
        end
        if (adv[1])
        begin
            weight_reg <= weight_next;
        end
    end

    assign lane_adv = '{prod: adv[2], pair: adv[3], sum: adv[4], out: adv[5]};

    cbpe_blend u_lane_x (
        .clk    (clk),
        .adv    (lane_adv),
        .weight (weight_reg),
        .ctrl   (ctrl_x_reg),
        .point  (point_x)
    );

    cbpe_blend u_lane_y (
        .clk    (clk),
        .adv    (lane_adv),
        .weight (weight_reg),
        .ctrl   (ctrl_y_reg),
        .point  (point_y)
    );

    // Stall the step channel only when stage one is full and blocked.
    `CBPE_ASSERT(a_stall_only_when_full, step_stall |-> valid_reg[0])
    // An accepted request lands in stage one.
    `CBPE_ASSERT(a_accept_lands, (step_valid && !step_stall) |=> valid_reg[0])
    // A free output lets the whole pipe move.
    `CBPE_ASSERT(a_free_moves_all, !point_stall |-> (&adv))
    // A full sum stage that advances presents a point next cycle.
    `CBPE_ASSERT(a_last_reaches_out,
        (valid_reg[NUM_STAGES-2] && adv[NUM_STAGES-1]) |=> point_valid)

endmodule

[verif/tb_cubic_bezier_point_evaluator.sv]
`timescale 1ns / 100ps

module tb_cubic_bezier_point_evaluator;
    import cbpe_pkg::*;

    // Six register stages from step acceptance to point_valid.
    localparam int PIPE_LATENCY   = 6;
    // Give up after this many cycles in which neither channel moves a request.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int STEPS_PER_PHASE = 168;

    localparam coord_t COORD_MAX = 16'sh7FFF;
    localparam coord_t COORD_MIN = 16'sh8000;
    localparam logic [STEP_BITS-1:0] STEP_LAST = {STEP_BITS{1'b1}};

    typedef struct {
        coord_t x;
        coord_t y;
    } curve_pt_t;

    // A point typed in by hand overrides the predictor for that request.
    typedef struct {
        bit     fixed;
        coord_t x;
        coord_t y;
    } pinned_pt_t;

    typedef enum bit { ROW_WRITE, ROW_STEP } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        cfg_reg_t            sel;
        coord_t              data;
        logic [STEP_BITS-1:0] step;
        bit                  fixed;
        coord_t              x;
        coord_t              y;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;
    logic                   step_valid;
    logic                   step_stall;
    logic [STEP_BITS-1:0]   step_index;
    logic                   point_valid;
    logic                   point_stall;
    coord_t                 point_x;
    coord_t                 point_y;

    cubic_bezier_point_evaluator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_valid  (step_valid),
        .step_stall  (step_stall),
        .step_index  (step_index),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_x     (point_x),
        .point_y     (point_y)
    );

    // Shadow copy of the control points, updated at the same edge as the block.
    coord_t ctrl_x [NUM_POINTS];
    coord_t ctrl_y [NUM_POINTS];

    curve_pt_t  expected_points [$];
    pinned_pt_t pinned_points [$];
    stim_row_t  stim_rows [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int idle_cycles;
    int err_count;
    int steps_taken;
    int points_checked;
    int curve_settings;

    curve_pt_t  want;
    curve_pt_t  got;
    pinned_pt_t pin;
    bit         moved;

    // Clock: 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Blend one axis: exact 64-bit weighted sum, one division by N^3.
    // SystemVerilog signed division truncates toward zero, as required.
    function automatic coord_t blend_axis(longint w0, longint w1, longint w2, longint w3,
                                          coord_t p0, coord_t p1, coord_t p2, coord_t p3);
        longint acc;
        longint den;
        longint quo;
        acc = w0 * longint'(p0) + w1 * longint'(p1) + w2 * longint'(p2)
            + w3 * longint'(p3);
        den = longint'(1) << (3 * STEP_BITS);
        quo = acc / den;
        return coord_t'(quo[COORD_WIDTH-1:0]);
    endfunction

    // Curve point at t = step / 2^STEP_BITS under the shadow control points.
    function automatic curve_pt_t bezier_point(logic [STEP_BITS-1:0] step);
        longint ti;
        longint ta;
        longint w0, w1, w2, w3;
        curve_pt_t pt;
        ti = longint'(step);
        ta = (longint'(1) << STEP_BITS) - ti;
        w0 = ta * ta * ta;
        w1 = 3 * ti * ta * ta;
        w2 = 3 * ti * ti * ta;
        w3 = ti * ti * ti;
        pt.x = blend_axis(w0, w1, w2, w3, ctrl_x[0], ctrl_x[1], ctrl_x[2], ctrl_x[3]);
        pt.y = blend_axis(w0, w1, w2, w3, ctrl_y[0], ctrl_y[1], ctrl_y[2], ctrl_y[3]);
        return pt;
    endfunction

    // Favor the coordinate extremes and zero, otherwise any 16-bit value.
    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(9))
            0: return '0;
            1: return STEP_LAST;
            default: return STEP_BITS'($urandom_range(255));
        endcase
    endfunction

    // Monitor: track register writes, predict each accepted request, and check
    // each accepted point against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_wr_en)
            begin
                if (cfg_index < REG_Y0)
                    ctrl_x[cfg_index[1:0]] = coord_t'(cfg_data);
                else
                    ctrl_y[cfg_index[1:0]] = coord_t'(cfg_data);
            end
            if (step_valid && !step_stall)
            begin
                pin = pinned_points.pop_front();
                if (pin.fixed)
                begin
                    want.x = pin.x;
                    want.y = pin.y;
                end
                else
                    want = bezier_point(step_index);
                expected_points.push_back(want);
                steps_taken++;
                moved = 1'b1;
            end
            if (point_valid && !point_stall)
            begin
                moved = 1'b1;
                if (expected_points.size() == 0)
                begin
                    err_count++;
                    $display("%0t: point expected none, got (%0d, %0d)",
                             $time, point_x, point_y);
                end
                else
                begin
                    got = expected_points.pop_front();
                    points_checked++;
                    if (point_x !== got.x)
                    begin
                        err_count++;
                        $display("%0t: point_x expected %0d, got %0d",
                                 $time, got.x, point_x);
                    end
                    if (point_y !== got.y)
                    begin
                        err_count++;
                        $display("%0t: point_y expected %0d, got %0d",
                                 $time, got.y, point_y);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Receiver backpressure: redraw the stall at every falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            point_stall = ($urandom_range(99) < receiver_stall_pct);
    end

    // Watchdog: end the run if traffic stops for too long.
    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no request moved for %0d cycles, %0d points still owed",
                 $time, WATCHDOG_LIMIT, expected_points.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one request; call and return at a falling edge. Valid stays high
    // on return so back-to-back requests need no gap.
    task automatic send_step(logic [STEP_BITS-1:0] step, bit fixed, coord_t x, coord_t y);
        pinned_pt_t p;
        p.fixed = fixed;
        p.x = x;
        p.y = y;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            step_valid = 1'b0;
            step_index = STEP_BITS'($urandom);
            @(negedge clk);
        end
        pinned_points.push_back(p);
        step_valid = 1'b1;
        step_index = step;
        @(posedge clk);
        while (step_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and let every outstanding point drain before touching registers.
    task automatic wait_drained();
        step_valid = 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Drive one register write for one cycle; the caller drops the enable.
    task automatic write_reg(cfg_reg_t sel, coord_t data);
        cfg_wr_en = 1'b1;
        cfg_index = sel;
        cfg_data  = data;
        @(negedge clk);
    endtask

    task automatic add_write(cfg_reg_t sel, coord_t data);
        stim_row_t r;
        r = '{kind: ROW_WRITE, sel: sel, data: data, step: '0, fixed: 1'b0, x: '0, y: '0};
        stim_rows.push_back(r);
    endtask

    task automatic add_step(logic [STEP_BITS-1:0] step, bit fixed, coord_t x, coord_t y);
        stim_row_t r;
        r = '{kind: ROW_STEP, sel: REG_X0, data: '0, step: step, fixed: fixed, x: x, y: y};
        stim_rows.push_back(r);
    endtask

    initial
    begin : main
        cfg_reg_t sel;

        // Hold every input at a known value through reset.
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_X0;
        cfg_data           = '0;
        step_valid         = 1'b0;
        step_index         = '0;
        point_stall        = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        idle_cycles        = 0;
        err_count          = 0;
        steps_taken        = 0;
        points_checked     = 0;
        curve_settings     = 1;
        for (int k = 0; k < NUM_POINTS; k++)
        begin
            ctrl_x[k] = '0;
            ctrl_y[k] = '0;
        end

        // Directed rows. After reset every control point is zero, so any step
        // lands on the origin.
        add_step('0, 1'b1, '0, '0);
        add_step(STEP_LAST, 1'b1, '0, '0);
        add_step(8'd128, 1'b1, '0, '0);
        // Alternate extremes: step zero returns the start point exactly; the
        // rest exercise large cancelling sums and truncation of negatives.
        add_write(REG_X0, COORD_MIN);
        add_write(REG_X1, COORD_MAX);
        add_write(REG_X2, COORD_MIN);
        add_write(REG_X3, COORD_MAX);
        add_write(REG_Y0, COORD_MAX);
        add_write(REG_Y1, COORD_MIN);
        add_write(REG_Y2, COORD_MAX);
        add_write(REG_Y3, COORD_MIN);
        add_step('0, 1'b1, COORD_MIN, COORD_MAX);
        add_step(STEP_LAST, 1'b0, '0, '0);
        add_step(8'd1, 1'b0, '0, '0);
        add_step(8'd128, 1'b0, '0, '0);
        add_step(8'hAA, 1'b0, '0, '0);
        add_step(8'h55, 1'b0, '0, '0);
        // Coincident control points: the weights sum to N^3, so every step
        // returns that point unchanged.
        add_write(REG_X0, COORD_MAX);
        add_write(REG_X1, COORD_MAX);
        add_write(REG_X2, COORD_MAX);
        add_write(REG_X3, COORD_MAX);
        add_write(REG_Y0, COORD_MIN);
        add_write(REG_Y1, COORD_MIN);
        add_write(REG_Y2, COORD_MIN);
        add_write(REG_Y3, COORD_MIN);
        add_step('0, 1'b1, COORD_MAX, COORD_MIN);
        add_step(STEP_LAST, 1'b1, COORD_MAX, COORD_MIN);
        add_step(8'd77, 1'b1, COORD_MAX, COORD_MIN);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed rows; drain before the first write of each batch.
        for (int r = 0; r < stim_rows.size(); r++)
        begin
            if (stim_rows[r].kind == ROW_WRITE)
            begin
                if (r == 0 || stim_rows[r-1].kind != ROW_WRITE)
                begin
                    wait_drained();
                    curve_settings++;
                end
                write_reg(stim_rows[r].sel, stim_rows[r].data);
            end
            else
            begin
                cfg_wr_en = 1'b0;
                send_step(stim_rows[r].step, stim_rows[r].fixed,
                          stim_rows[r].x, stim_rows[r].y);
            end
        end

        // Random phases: new control points each time, cycling through the
        // idle patterns (none, sender gaps, receiver stalls, light on both).
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            sel = sel.first();
            for (int k = 0; k < 2 * NUM_POINTS; k++)
            begin
                write_reg(sel, pick_coord());
                sel = sel.next();
            end
            cfg_wr_en = 1'b0;
            curve_settings++;
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            for (int n = 0; n < STEPS_PER_PHASE; n++)
                send_step(pick_step(), 1'b0, '0, '0);
        end

        // Drain, then allow the pipeline depth for any stray point to show up.
        wait_drained();
        receiver_stall_pct = 0;
        repeat (PIPE_LATENCY + 4) @(negedge clk);

        $display("Checked %0d curve points from %0d step requests across %0d control-point sets,",
                 points_checked, steps_taken, curve_settings);
        $display("under free-running, sender-gap, receiver-stall and mixed traffic.");
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
